/* design/ctg_pkg.sv */
// shared types and constants of the cubic trajectory guidance block
`default_nettype none
package ctg_pkg;

    // configuration register indexes
    typedef enum logic [7:0] {
        REG_START_POS  = 8'd0,
        REG_START_VEL  = 8'd1,
        REG_TARGET_POS = 8'd2,
        REG_TARGET_VEL = 8'd3,
        REG_MAN_LEN    = 8'd4
    } cfg_reg_e;

    // stages from the input register to the curve results
    localparam int AX_LAT = 51;

    typedef struct packed {
        logic        [31:0] t_since_start;
        logic signed [31:0] current_pos_x;
        logic signed [31:0] current_pos_y;
        logic signed [31:0] current_vel_x;
        logic signed [31:0] current_vel_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_error_x;
        logic signed [31:0] pos_error_y;
        logic signed [31:0] vel_error_x;
        logic signed [31:0] vel_error_y;
        logic        [31:0] time_left;
        logic signed [31:0] ref_pos_x;
        logic signed [31:0] ref_pos_y;
        logic signed [31:0] ref_vel_x;
        logic signed [31:0] ref_vel_y;
        logic signed [31:0] ref_acc_x;
        logic signed [31:0] ref_acc_y;
        logic               zero_duration;
    } out_item_t;

    // per-axis view of the configuration
    typedef struct packed {
        logic signed [31:0] p0;
        logic signed [31:0] v0;
        logic signed [31:0] p1;
        logic signed [31:0] v1;
        logic        [31:0] tm;
    } axis_cfg_t;

    // curve results of one axis
    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
    } axis_res_t;

endpackage
`default_nettype wire

/* design/ctg_axis.sv */
// one axis of the curve: pipelined wide multipliers and rounding dividers
`default_nettype none
module ctg_axis (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire ctg_pkg::axis_cfg_t cfg,
    input  wire logic [31:0]        t_in,
    output ctg_pkg::axis_res_t      res
);
    import ctg_pkg::*;

    localparam int MW    = 160;
    localparam int NLIMB = MW / 32;
    localparam int PPW   = 66;
    localparam int SW    = 99;
    localparam int PW    = MW + 33;
    localparam int NL    = 11;
    localparam int NUMW  = 170;
    localparam int NW    = 172;
    localparam int DENW  = 112;
    localparam int NDIV  = 3;
    localparam int NBIT  = 33;

    // multiplier lanes
    localparam int L_T2 = 0;
    localparam int L_T3 = 1;
    localparam int L_DT = 2;
    localparam int L_ET = 3;
    localparam int L_Q  = 4;
    localparam int L_V  = 5;
    localparam int L_K  = 6;
    localparam int L_P  = 7;
    localparam int L_R1 = 8;
    localparam int L_R2 = 9;
    localparam int L_R3 = 10;

    logic signed [MW-1:0] mx [NL];
    logic signed [32:0]   mb [NL];
    logic                 me [NL];
    logic signed [PW-1:0] mp [NL];

    // wide by 33-bit multiplier: partial products, pair sums, final sum
    for (genvar l = 0; l < NL; l++) begin : g_mul
        logic signed [PPW-1:0] pp_reg [NLIMB];
        logic signed [PPW-1:0] pp_next [NLIMB];
        logic signed [SW-1:0]  s_reg [3];
        logic signed [SW-1:0]  s_next [3];
        logic signed [PW-1:0]  p_reg;
        logic signed [PW-1:0]  p_next;

        always_comb begin
            logic signed [32:0] limb;
            for (int j = 0; j < NLIMB; j++) begin
                if (j < NLIMB - 1) begin
                    limb = $signed({1'b0, mx[l][32*j +: 32]});
                end else begin
                    limb = 33'($signed(mx[l][MW-1 -: 32]));
                end
                pp_next[j] = limb * mb[l];
            end
            s_next[0] = SW'(pp_reg[0]) + (SW'(pp_reg[1]) <<< 32);
            s_next[1] = SW'(pp_reg[2]) + (SW'(pp_reg[3]) <<< 32);
            s_next[2] = SW'(pp_reg[4]);
            p_next    = PW'(s_reg[0]) + (PW'(s_reg[1]) <<< 64) + (PW'(s_reg[2]) <<< 128);
        end

        always_ff @(posedge aclk) begin
            if (me[l]) begin
                pp_reg <= pp_next;
                s_reg  <= s_next;
                p_reg  <= p_next;
            end
        end

        assign mp[l] = p_reg;
    end

    // configuration side, free running
    logic signed [32:0]  tt;
    logic signed [64:0]  t2;
    logic signed [96:0]  t3;
    logic signed [33:0]  d_val;
    logic signed [32:0]  e_val;
    logic signed [32:0]  dp;
    logic signed [67:0]  dp68;
    logic signed [67:0]  a_reg;
    logic signed [67:0]  a_next;
    logic signed [67:0]  b_reg;
    logic signed [67:0]  b_next;
    logic [DENW-1:0]     den [NDIV];

    always_comb begin
        tt     = $signed({1'b0, cfg.tm});
        t2     = $signed(mp[L_T2][64:0]);
        t3     = $signed(mp[L_T3][96:0]);
        d_val  = (34'(cfg.v0) <<< 1) + 34'(cfg.v1);
        e_val  = 33'(cfg.v0) + 33'(cfg.v1);
        dp     = 33'(cfg.p1) - 33'(cfg.p0);
        dp68   = 68'(dp);
        a_next = (((dp68 <<< 1) + dp68) <<< 16) - $signed(mp[L_DT][67:0]);
        b_next = $signed(mp[L_ET][67:0]) - (dp68 <<< 17);
        den[0] = DENW'({mp[L_T3][95:0], 16'd0});
        den[1] = DENW'(mp[L_T3][95:0]);
        den[2] = DENW'(mp[L_T3][95:0]);
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    // item side registers
    logic [31:0]            t_pipe_reg [1:11];
    logic signed [103:0]    m1_reg, m1_next;
    logic signed [103:0]    m2_reg, m2_next;
    logic signed [120:0]    acc_next;
    logic signed [120:0]    acc_dly_reg [0:8];
    logic signed [136:0]    vel_next;
    logic signed [136:0]    vel_dly_reg [0:4];
    logic signed [136:0]    inner_reg, inner_next;
    logic signed [NUMW-1:0] posn_reg, posn_next;
    logic signed [NUMW-1:0] num [NDIV];

    // lane operand selection
    always_comb begin
        mx[L_T2] = MW'(tt);            mb[L_T2] = tt;          me[L_T2] = 1'b1;
        mx[L_T3] = MW'(t2);            mb[L_T3] = tt;          me[L_T3] = 1'b1;
        mx[L_DT] = MW'(d_val);         mb[L_DT] = tt;          me[L_DT] = 1'b1;
        mx[L_ET] = MW'(e_val);         mb[L_ET] = tt;          me[L_ET] = 1'b1;
        mx[L_Q]  = MW'(a_reg);         mb[L_Q]  = tt;          me[L_Q]  = 1'b1;
        mx[L_V]  = MW'(t3);            mb[L_V]  = 33'(cfg.v0); me[L_V]  = 1'b1;
        mx[L_K]  = MW'(t3);            mb[L_K]  = 33'(cfg.p0); me[L_K]  = 1'b1;
        mx[L_P]  = MW'(b_reg);
        mb[L_P]  = $signed({1'b0, t_pipe_reg[3]});
        me[L_P]  = en;
        mx[L_R1] = MW'(m1_reg);
        mb[L_R1] = $signed({1'b0, t_pipe_reg[7]});
        me[L_R1] = en;
        mx[L_R2] = MW'(m2_reg);
        mb[L_R2] = $signed({1'b0, t_pipe_reg[7]});
        me[L_R2] = en;
        mx[L_R3] = MW'(inner_reg);
        mb[L_R3] = $signed({1'b0, t_pipe_reg[11]});
        me[L_R3] = en;
    end

    // numerators: acc = k(6P+2Q), vel = t(3P+2Q)+V, pos = t(t(P+Q)+V)+kK
    always_comb begin
        logic signed [103:0] pe, qe;
        logic signed [120:0] pa, qa;
        pe         = 104'($signed(mp[L_P][100:0]));
        qe         = 104'($signed(mp[L_Q][100:0]));
        pa         = 121'(pe);
        qa         = 121'(qe);
        m1_next    = (pe <<< 1) + pe + (qe <<< 1);
        m2_next    = pe + qe;
        acc_next   = ((pa <<< 2) + (pa <<< 1) + (qa <<< 1)) <<< 16;
        vel_next   = 137'($signed(mp[L_R1][135:0])) + 137'($signed(mp[L_V][128:0]));
        inner_next = 137'($signed(mp[L_R2][135:0])) + 137'($signed(mp[L_V][128:0]));
        posn_next  = NUMW'($signed(mp[L_R3][168:0]))
                   + (NUMW'($signed(mp[L_K][128:0])) <<< 16);
        num[0]     = posn_reg;
        num[1]     = NUMW'(vel_dly_reg[4]);
        num[2]     = NUMW'(acc_dly_reg[8]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_pipe_reg[1] <= t_in;
            for (int s = 2; s <= 11; s++) t_pipe_reg[s] <= t_pipe_reg[s-1];
            m1_reg         <= m1_next;
            m2_reg         <= m2_next;
            acc_dly_reg[0] <= acc_next;
            for (int s = 1; s <= 8; s++) acc_dly_reg[s] <= acc_dly_reg[s-1];
            vel_dly_reg[0] <= vel_next;
            for (int s = 1; s <= 4; s++) vel_dly_reg[s] <= vel_dly_reg[s-1];
            inner_reg      <= inner_next;
            posn_reg       <= posn_next;
        end
    end

    // rounding divider: magnitude, offset numerator, one quotient bit a stage
    logic signed [31:0] q_out [NDIV];

    for (genvar d = 0; d < NDIV; d++) begin : g_div
        logic            neg_a_reg, neg_b_reg;
        logic [NUMW-1:0] mag_reg, mag_next;
        logic [NW-1:0]   n2_reg, n2_next;
        logic [NW-1:0]   d2;
        logic [NW-1:0]   rem_reg [NBIT];
        logic [NW-1:0]   rem_next [NBIT];
        logic [NBIT-1:0] qb_reg [NBIT];
        logic [NBIT-1:0] qb_next [NBIT];
        logic            ovf_reg [NBIT];
        logic            ovf_next [NBIT];
        logic            neg_reg [NBIT];
        logic [31:0]     o_reg, o_next;

        always_comb begin
            logic signed [NUMW:0] sx;
            logic [NW-1:0]        cmpv;
            logic [NBIT-1:0]      lim, qs;
            sx       = (NUMW+1)'(num[d]);
            mag_next = NUMW'(num[d][NUMW-1] ? -sx : sx);
            d2       = NW'(den[d]) << 1;
            n2_next  = (NW'(mag_reg) << 1) + NW'(den[d]);
            // top bit also decides overflow past the quotient range
            cmpv        = d2 << (NBIT - 1);
            ovf_next[0] = n2_reg >= (d2 << NBIT);
            rem_next[0] = (n2_reg >= cmpv) ? n2_reg - cmpv : n2_reg;
            qb_next[0]  = (n2_reg >= cmpv) ? NBIT'(1) << (NBIT - 1) : '0;
            for (int b = 1; b < NBIT; b++) begin
                cmpv        = d2 << (NBIT - 1 - b);
                ovf_next[b] = ovf_reg[b-1];
                rem_next[b] = (rem_reg[b-1] >= cmpv) ? rem_reg[b-1] - cmpv : rem_reg[b-1];
                qb_next[b]  = qb_reg[b-1]
                            | ((rem_reg[b-1] >= cmpv) ? NBIT'(1) << (NBIT - 1 - b) : '0);
            end
            // clamp and apply sign
            lim    = neg_reg[NBIT-1] ? NBIT'(33'h0_8000_0000) : NBIT'(33'h0_7FFF_FFFF);
            qs     = (ovf_reg[NBIT-1] || qb_reg[NBIT-1] > lim) ? lim : qb_reg[NBIT-1];
            o_next = neg_reg[NBIT-1] ? -qs[31:0] : qs[31:0];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                neg_a_reg  <= num[d][NUMW-1];
                mag_reg    <= mag_next;
                neg_b_reg  <= neg_a_reg;
                n2_reg     <= n2_next;
                neg_reg[0] <= neg_b_reg;
                for (int b = 1; b < NBIT; b++) neg_reg[b] <= neg_reg[b-1];
                rem_reg    <= rem_next;
                qb_reg     <= qb_next;
                ovf_reg    <= ovf_next;
                o_reg      <= o_next;
            end
        end

        assign q_out[d] = $signed(o_reg);
    end

    assign res.pos = q_out[0];
    assign res.vel = q_out[1];
    assign res.acc = q_out[2];

endmodule
`default_nettype wire

/* design/cubic_trajectory_guidance_top.sv */
// top level of the cubic trajectory guidance block
//
//  channel  ports                              dir   moves
//  cfg      cfg_valid/ready, cfg_index/data    in    register write request
//  s        s_valid/ready, s_data              in    guidance sample request
//  m        m_valid/ready, m_data              out   guidance result request
//
// one sample per cycle sustained while no result is held at the output; each
// result passes through the chained wide multipliers and then the 33-stage
// restoring divider that rounds every curve output.
// reset clears the valid chain and the configuration registers, the duration to 65536; no clearing pass.
// both ready outputs are held low while reset is asserted.
// a result held at the output freezes the whole pipeline until taken.
`default_nettype none
module cubic_trajectory_guidance_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ctg_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ctg_pkg::out_item_t      m_data
);
    import ctg_pkg::*;

    typedef struct packed {
        logic signed [31:0] pos_error_x;
        logic signed [31:0] pos_error_y;
        logic signed [31:0] vel_error_x;
        logic signed [31:0] vel_error_y;
        logic        [31:0] time_left;
        logic               zero_duration;
    } base_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic [63:0] start_pos_reg, start_vel_reg, target_pos_reg, target_vel_reg;
    logic [31:0] len_reg;

    // configuration registers
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pos_reg  <= '0;
            start_vel_reg  <= '0;
            target_pos_reg <= '0;
            target_vel_reg <= '0;
            len_reg        <= 32'd65536;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_START_POS:  start_pos_reg  <= cfg_data;
                REG_START_VEL:  start_vel_reg  <= cfg_data;
                REG_TARGET_POS: target_pos_reg <= cfg_data;
                REG_TARGET_VEL: target_vel_reg <= cfg_data;
                REG_MAN_LEN:    len_reg        <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // pipeline advance and valid chain
    logic     en;
    logic     vld_reg [0:AX_LAT];
    in_item_t in_reg;
    base_t    bas_reg [1:AX_LAT];
    base_t    bas_next;

    assign en      = !vld_reg[AX_LAT] || m_ready;
    assign s_ready = en && aresetn;
    assign m_valid = vld_reg[AX_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= AX_LAT; s++) vld_reg[s] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int s = 1; s <= AX_LAT; s++) vld_reg[s] <= vld_reg[s-1];
        end
    end

    // errors, time left and duration flag
    always_comb begin
        bas_next.pos_error_x = sat33(33'($signed(target_pos_reg[63:32]))
                                     - 33'(in_reg.current_pos_x));
        bas_next.pos_error_y = sat33(33'($signed(target_pos_reg[31:0]))
                                     - 33'(in_reg.current_pos_y));
        bas_next.vel_error_x = sat33(33'($signed(target_vel_reg[63:32]))
                                     - 33'(in_reg.current_vel_x));
        bas_next.vel_error_y = sat33(33'($signed(target_vel_reg[31:0]))
                                     - 33'(in_reg.current_vel_y));
        bas_next.time_left   = (len_reg > in_reg.t_since_start)
                             ? len_reg - in_reg.t_since_start : 32'd0;
        bas_next.zero_duration = (len_reg == 32'd0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg     <= s_data;
            bas_reg[1] <= bas_next;
            for (int s = 2; s <= AX_LAT; s++) bas_reg[s] <= bas_reg[s-1];
        end
    end

    // curve per axis
    axis_cfg_t cfg_x, cfg_y;
    axis_res_t res_x, res_y;

    always_comb begin
        cfg_x.p0 = $signed(start_pos_reg[63:32]);
        cfg_x.v0 = $signed(start_vel_reg[63:32]);
        cfg_x.p1 = $signed(target_pos_reg[63:32]);
        cfg_x.v1 = $signed(target_vel_reg[63:32]);
        cfg_x.tm = len_reg;
        cfg_y.p0 = $signed(start_pos_reg[31:0]);
        cfg_y.v0 = $signed(start_vel_reg[31:0]);
        cfg_y.p1 = $signed(target_pos_reg[31:0]);
        cfg_y.v1 = $signed(target_vel_reg[31:0]);
        cfg_y.tm = len_reg;
    end

    ctg_axis u_axis_x (
        .aclk (aclk),
        .en   (en),
        .cfg  (cfg_x),
        .t_in (in_reg.t_since_start),
        .res  (res_x)
    );

    ctg_axis u_axis_y (
        .aclk (aclk),
        .en   (en),
        .cfg  (cfg_y),
        .t_in (in_reg.t_since_start),
        .res  (res_y)
    );

    // result assembly, curve zeroed for a zero duration
    always_comb begin
        m_data.pos_error_x   = bas_reg[AX_LAT].pos_error_x;
        m_data.pos_error_y   = bas_reg[AX_LAT].pos_error_y;
        m_data.vel_error_x   = bas_reg[AX_LAT].vel_error_x;
        m_data.vel_error_y   = bas_reg[AX_LAT].vel_error_y;
        m_data.time_left     = bas_reg[AX_LAT].time_left;
        m_data.zero_duration = bas_reg[AX_LAT].zero_duration;
        if (bas_reg[AX_LAT].zero_duration) begin
            m_data.ref_pos_x = '0;
            m_data.ref_pos_y = '0;
            m_data.ref_vel_x = '0;
            m_data.ref_vel_y = '0;
            m_data.ref_acc_x = '0;
            m_data.ref_acc_y = '0;
        end else begin
            m_data.ref_pos_x = res_x.pos;
            m_data.ref_pos_y = res_y.pos;
            m_data.ref_vel_x = res_x.vel;
            m_data.ref_vel_y = res_y.vel;
            m_data.ref_acc_x = res_x.acc;
            m_data.ref_acc_y = res_y.acc;
        end
    end

    // checks
    a_flag_matches_len : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.zero_duration == (len_reg == 32'd0)))
        else $error("duration flag out of step with duration register");

    a_time_left_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.time_left <= len_reg))
        else $error("time left exceeds duration");

    a_zero_curve : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.zero_duration) |->
        (m_data.ref_pos_x == 0 && m_data.ref_vel_y == 0 && m_data.ref_acc_x == 0))
        else $error("curve not zeroed for zero duration");

    a_stall_freezes : assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg[0]) && $stable(vld_reg[AX_LAT / 2]))
        else $error("valid chain moved during a stall");

endmodule
`default_nettype wire

/* sim/cubic_trajectory_guidance_checker.sv */
// checker for the cubic trajectory guidance block: prediction and comparison of results
`default_nettype none
module cubic_trajectory_guidance_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire ctg_pkg::in_item_t  s_data,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire ctg_pkg::out_item_t m_data,
    output int                      fail_count,
    output int                      pending
);
    import ctg_pkg::*;

    // shadow copy of the configuration registers
    logic [63:0] sh_start_pos, sh_start_vel, sh_target_pos, sh_target_vel;
    logic [31:0] sh_length;

    out_item_t guidance_q[$];

    // exact rational rounded to nearest, ties away from zero, saturated
    function automatic logic signed [31:0] round_sat(logic signed [255:0] num,
                                                     logic signed [255:0] den);
        logic        [255:0] mag;
        logic        [255:0] quo;
        logic                neg;
        neg = num < 0;
        mag = neg ? -num : num;
        quo = (2 * mag + den) / (2 * den);
        if (neg) begin
            if (quo > 256'h8000_0000) quo = 256'h8000_0000;
            return -quo[31:0];
        end
        if (quo > 256'h7FFF_FFFF) quo = 256'h7FFF_FFFF;
        return quo[31:0];
    endfunction

    function automatic logic signed [31:0] sat_diff(logic signed [31:0] a,
                                                    logic signed [31:0] b);
        logic signed [33:0] d;
        d = 34'(a) - 34'(b);
        if (d > 34'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (d < -34'sh8000_0000) return 32'sh8000_0000;
        return d[31:0];
    endfunction

    // curve position, velocity and acceleration of one axis
    function automatic axis_res_t curve_axis(logic signed [31:0] p0, logic signed [31:0] v0,
                                             logic signed [31:0] p1, logic signed [31:0] v1,
                                             logic [31:0] tr, logic [31:0] tlen);
        logic signed [255:0] t, tt, t2, t3, t3len, dp, a, b, k, num;
        axis_res_t r;
        t = {224'b0, tr};
        tt = {224'b0, tlen};
        k = 256'sd65536;
        t2 = t * t;
        t3 = t2 * t;
        t3len = tt * tt * tt;
        dp = 256'(p1) - 256'(p0);
        a = 3 * dp * k - (2 * 256'(v0) + 256'(v1)) * tt;
        b = -2 * dp * k + (256'(v0) + 256'(v1)) * tt;
        num = 256'(p0) * k * t3len + 256'(v0) * t * t3len + a * t2 * tt + b * t3;
        r.pos = round_sat(num, k * t3len);
        num = 256'(v0) * t3len + 2 * a * t * tt + 3 * b * t2;
        r.vel = round_sat(num, t3len);
        num = k * (2 * a * tt + 6 * b * t);
        r.acc = round_sat(num, t3len);
        return r;
    endfunction

    function automatic out_item_t predict_guidance(in_item_t s);
        out_item_t o;
        axis_res_t rx, ry;
        o = '0;
        o.pos_error_x = sat_diff(sh_target_pos[63:32], s.current_pos_x);
        o.pos_error_y = sat_diff(sh_target_pos[31:0], s.current_pos_y);
        o.vel_error_x = sat_diff(sh_target_vel[63:32], s.current_vel_x);
        o.vel_error_y = sat_diff(sh_target_vel[31:0], s.current_vel_y);
        o.time_left = (sh_length > s.t_since_start) ? sh_length - s.t_since_start : '0;
        if (sh_length == 0) begin
            o.zero_duration = 1'b1;
        end else begin
            rx = curve_axis(sh_start_pos[63:32], sh_start_vel[63:32], sh_target_pos[63:32],
                            sh_target_vel[63:32], s.t_since_start, sh_length);
            ry = curve_axis(sh_start_pos[31:0], sh_start_vel[31:0], sh_target_pos[31:0],
                            sh_target_vel[31:0], s.t_since_start, sh_length);
            o.ref_pos_x = rx.pos;
            o.ref_pos_y = ry.pos;
            o.ref_vel_x = rx.vel;
            o.ref_vel_y = ry.vel;
            o.ref_acc_x = rx.acc;
            o.ref_acc_y = ry.acc;
        end
        return o;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // watch the channels
    always @(posedge aclk) begin
        out_item_t w;
        if (!aresetn) begin
            sh_start_pos <= '0;
            sh_start_vel <= '0;
            sh_target_pos <= '0;
            sh_target_vel <= '0;
            sh_length <= 32'd65536;
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_START_POS:  sh_start_pos <= cfg_data;
                    REG_START_VEL:  sh_start_vel <= cfg_data;
                    REG_TARGET_POS: sh_target_pos <= cfg_data;
                    REG_TARGET_VEL: sh_target_vel <= cfg_data;
                    REG_MAN_LEN:    sh_length <= cfg_data[31:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) guidance_q.push_back(predict_guidance(s_data));
            if (m_valid && m_ready) begin
                if (guidance_q.size() == 0) begin
                    $error("result request with nothing expected");
                    fail_count++;
                end else begin
                    w = guidance_q.pop_front();
                    compare_field("pos_error_x", w.pos_error_x, m_data.pos_error_x);
                    compare_field("pos_error_y", w.pos_error_y, m_data.pos_error_y);
                    compare_field("vel_error_x", w.vel_error_x, m_data.vel_error_x);
                    compare_field("vel_error_y", w.vel_error_y, m_data.vel_error_y);
                    compare_field("time_left", w.time_left, m_data.time_left);
                    compare_field("ref_pos_x", w.ref_pos_x, m_data.ref_pos_x);
                    compare_field("ref_pos_y", w.ref_pos_y, m_data.ref_pos_y);
                    compare_field("ref_vel_x", w.ref_vel_x, m_data.ref_vel_x);
                    compare_field("ref_vel_y", w.ref_vel_y, m_data.ref_vel_y);
                    compare_field("ref_acc_x", w.ref_acc_x, m_data.ref_acc_x);
                    compare_field("ref_acc_y", w.ref_acc_y, m_data.ref_acc_y);
                    compare_field("zero_duration", 32'(w.zero_duration),
                                  32'(m_data.zero_duration));
                end
            end
        end
        // requests still waiting for their result
        pending <= guidance_q.size();
    end

endmodule
`default_nettype wire

/* sim/cubic_trajectory_guidance_top_tb.sv */
// stimulus and verdict for the cubic trajectory guidance block
`default_nettype none
module cubic_trajectory_guidance_top_tb;
    import ctg_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    int          fail_count;
    int          pending;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          quiet_cycles = 0;

    localparam int WATCHDOG = 20000;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    cubic_trajectory_guidance_top dut (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
    );

    cubic_trajectory_guidance_checker chk (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .fail_count, .pending
    );

    // receiver stalls at random
    always @(posedge aclk) m_ready <= ($urandom_range(99) >= recv_idle);

    // watchdog on cycles with no accepted request
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_e idx, logic [63:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // valid stays up after the request until the next one or an idle cycle
    task automatic send_sample(in_item_t item);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (AX_LAT + 8) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_time(logic [31:0] tlen);
        case ($urandom_range(4))
            0: return $urandom();
            1: return tlen;
            default: return (tlen == 0) ? $urandom_range(1 << 18) : $urandom_range(tlen);
        endcase
    endfunction

    // one random setting of the trajectory registers
    task automatic random_setting(logic [31:0] tlen);
        write_reg(REG_START_POS, {rand_word(), rand_word()});
        write_reg(REG_START_VEL, {rand_word(), rand_word()});
        write_reg(REG_TARGET_POS, {rand_word(), rand_word()});
        write_reg(REG_TARGET_VEL, {rand_word(), rand_word()});
        write_reg(REG_MAN_LEN, {$urandom(), tlen});
    endtask

    initial begin
        in_item_t it;
        logic [31:0] tlen;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset setting, extremes, zero duration, time past duration
        for (int i = 0; i < 6; i++) begin
            it.t_since_start = (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFF_FFFF : 32'd65536 * i;
            it.current_pos_x = (i[0]) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            it.current_pos_y = (i[0]) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            it.current_vel_x = (i[1]) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            it.current_vel_y = (i[1]) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            send_sample(it);
        end
        drain();
        write_reg(REG_START_POS, 64'h8000_0000_7FFF_FFFF);
        write_reg(REG_START_VEL, 64'h7FFF_FFFF_8000_0000);
        write_reg(REG_TARGET_POS, 64'h7FFF_FFFF_8000_0000);
        write_reg(REG_TARGET_VEL, 64'h8000_0000_7FFF_FFFF);
        write_reg(REG_MAN_LEN, 64'd1);
        for (int i = 0; i < 5; i++) begin
            it = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            it.t_since_start = (i == 0) ? 32'd0 : (i == 1) ? 32'd1 : $urandom();
            send_sample(it);
        end
        drain();
        write_reg(REG_MAN_LEN, 64'hFFFF_FFFF_0000_0000);
        for (int i = 0; i < 4; i++) begin
            it = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            send_sample(it);
        end
        drain();
        write_reg(REG_MAN_LEN, 64'hFFFF_FFFF);
        for (int i = 0; i < 4; i++) begin
            it = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            it.t_since_start = (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'hFFFF_FFFE : $urandom();
            send_sample(it);
        end
        drain();
        // unmapped register index is ignored
        cfg_index <= 8'd5;
        cfg_data <= '1;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;

        // random phases: receiver idles most, then sender idles most, then neither
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 13 : (phase == 1) ? 68 : 0;
            recv_idle = (phase == 0) ? 68 : (phase == 1) ? 13 : 0;
            for (int blk = 0; blk < 8; blk++) begin
                drain();
                case ($urandom_range(5))
                    0: tlen = 32'd0;
                    1: tlen = $urandom();
                    default: tlen = $urandom_range(1 << 20, 1);
                endcase
                random_setting(tlen);
                for (int i = 0; i < 48; i++) begin
                    it.t_since_start = rand_time(tlen);
                    it.current_pos_x = rand_word();
                    it.current_pos_y = rand_word();
                    it.current_vel_x = rand_word();
                    it.current_vel_y = rand_word();
                    send_sample(it);
                    if (i == 20 && blk == 3) begin
                        s_valid <= 1'b0;
                        @(posedge aclk);
                        while (pending != 0) @(posedge aclk);
                    end
                end
            end
        end

        drain();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
